// ===== hdl/pixel_filter_pipeline_macros.svh =====
// ----------------------------------------------------------------------------
// pixel filter pipeline assertion macros
// concurrent checks clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PIXEL_FILTER_PIPELINE_MACROS_SVH
`define PIXEL_FILTER_PIPELINE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pfp_pkg
// shared constants, register indexes and configuration type of the pixel
// filter pipeline
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam int FIELD_BITS      = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PCT_BITS        = 7;
    localparam int CFG_INDEX_BITS  = 3;

    // register indexes on the config port
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VALUE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_MODE     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CONTOUR_EN     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEGATE_EN      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_EN   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_PCT  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAY_CONVERT   = 3'd6;

    localparam logic [FIELD_BITS-1:0] MAX_VALUE_RST = 16'd255;
    localparam logic [PCT_BITS-1:0]   PCT_RST       = 7'd50;

    // floor(x / 100) as (x * RECIP100_MUL) >> RECIP100_SHIFT, exact for x < 2^23
    localparam int                       RECIP100_SHIFT = 30;
    localparam int                       RECIP100_BITS  = 24;
    localparam logic [RECIP100_BITS-1:0] RECIP100_MUL   = 24'd10737419;

    // cycles the threshold level needs after a config write
    localparam int                 SETTLE_BITS   = 2;
    localparam logic [SETTLE_BITS-1:0] SETTLE_CYCLES = 2'd2;

    typedef struct packed {
        logic [FIELD_BITS-1:0] max_value;
        logic                  color_mode;
        logic                  contour_enable;
        logic                  negate_enable;
        logic                  threshold_enable;
        logic [PCT_BITS-1:0]   threshold_percent;
        logic                  gray_convert_enable;
    } cfg_t;

endpackage

// ===== hdl/pfp_if.sv =====
// ----------------------------------------------------------------------------
// pfp_if
// valid/ready channels for input pixels and filtered results
// ----------------------------------------------------------------------------
interface pfp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_or_gray;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last_of_image;

    modport source (output valid, output red_or_gray, output green, output blue,
                    output last_of_image, input ready);
    modport sink   (input valid, input red_or_gray, input green, input blue,
                    input last_of_image, output ready);
endinterface

interface pfp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red_or_gray;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic        out_last;

    modport source (output valid, output out_red_or_gray, output out_green,
                    output out_blue, output out_last, input ready);
    modport sink   (input valid, input out_red_or_gray, input out_green,
                    input out_blue, input out_last, output ready);
endinterface

// ===== hdl/pfp_thresh.sv =====
// ----------------------------------------------------------------------------
// pfp_thresh
// computes floor(max_value * percent / 100) in two registered multiply steps
// and flags the cycles in which the level is not yet valid
// ----------------------------------------------------------------------------
module pfp_thresh
    import pfp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [FIELD_BITS-1:0]  max_value,
    input  logic [PCT_BITS-1:0]    threshold_percent,
    output logic [SAMPLE_BITS:0]   level,
    output logic                   busy
);

    localparam int PROD_BITS  = SAMPLE_BITS + PCT_BITS;
    localparam int RECIP_BITS = PROD_BITS + RECIP100_BITS;

    logic [PROD_BITS-1:0]   prod_reg;
    logic [RECIP_BITS-1:0]  recip_reg;
    logic [SETTLE_BITS-1:0] settle_reg;
    logic [SETTLE_BITS-1:0] settle_next;

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_BITS'(max_value[SAMPLE_BITS-1:0]) * PROD_BITS'(threshold_percent);
        recip_reg <= RECIP_BITS'(prod_reg) * RECIP_BITS'(RECIP100_MUL);
    end

    always_comb
    begin
        if (cfg_we)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    assign level = recip_reg[RECIP100_SHIFT +: SAMPLE_BITS+1];
    assign busy  = (settle_reg != '0);

endmodule

// ===== hdl/pfp_point.sv =====
// ----------------------------------------------------------------------------
// pfp_point
// per-pixel point operations: negate, threshold and rgb to gray averaging
// ----------------------------------------------------------------------------
module pfp_point
    import pfp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  cfg_t                         cfg,
    input  logic [SAMPLE_BITS:0]         level,
    input  logic [2:0][SAMPLE_BITS-1:0]  px,
    output logic [2:0][SAMPLE_BITS-1:0]  res
);

    // floor(x / 3) as (x * DIV3_MUL) >> DIV3_SHIFT, exact for x < 2^(SAMPLE_BITS+2)
    localparam int DIV3_SHIFT = SAMPLE_BITS + 3;
    localparam int SUM_BITS   = SAMPLE_BITS + 2;
    localparam int DPROD_BITS = 2 * SUM_BITS;
    localparam logic [SUM_BITS-1:0] DIV3_MUL = SUM_BITS'(((1 << DIV3_SHIFT) + 2) / 3);

    logic [SAMPLE_BITS-1:0]  mx;
    logic [2:0][SAMPLE_BITS-1:0] s;
    logic [SUM_BITS-1:0]     sum;
    logic [DPROD_BITS-1:0]   dprod;
    logic [SAMPLE_BITS-1:0]  avg;

    function automatic logic [SAMPLE_BITS-1:0] point_op(
        input logic [SAMPLE_BITS-1:0] v,
        input logic [SAMPLE_BITS-1:0] mxv,
        input logic [SAMPLE_BITS:0]   lvl,
        input logic                   neg_en,
        input logic                   thr_en
    );
        logic [SAMPLE_BITS-1:0] t;
        t = v;
        if (neg_en)
        begin
            t = (mxv > t) ? (mxv - t) : '0;
        end
        if (thr_en)
        begin
            t = ({1'b0, t} <= lvl) ? '0 : mxv;
        end
        return t;
    endfunction

    always_comb
    begin
        mx   = cfg.max_value[SAMPLE_BITS-1:0];
        s[0] = point_op(px[0], mx, level, cfg.negate_enable, cfg.threshold_enable);
        // green and blue stay zero in gray mode
        s[1] = cfg.color_mode ?
               point_op(px[1], mx, level, cfg.negate_enable, cfg.threshold_enable) : '0;
        s[2] = cfg.color_mode ?
               point_op(px[2], mx, level, cfg.negate_enable, cfg.threshold_enable) : '0;

        sum   = SUM_BITS'(s[0]) + SUM_BITS'(s[1]) + SUM_BITS'(s[2]);
        dprod = DPROD_BITS'(sum) * DPROD_BITS'(DIV3_MUL);
        avg   = dprod[DIV3_SHIFT +: SAMPLE_BITS];

        if (cfg.color_mode && cfg.gray_convert_enable)
        begin
            res[0] = avg;
            res[1] = '0;
            res[2] = '0;
        end
        else
        begin
            res = s;
        end
    end

endmodule

// ===== hdl/pixel_filter_pipeline.sv =====
// ----------------------------------------------------------------------------
// pixel_filter_pipeline
// Takes a raster-order stream of gray or rgb pixels and applies contour,
// negate, threshold and gray conversion in that order as configured. One
// pixel is accepted per clock unless the output stalls; its first result
// leaves the output register in the next cycle. With contour on, a non-last
// pixel is held until its successor arrives and gives no result by itself. A
// pixel that produces two results (a last pixel releasing a held one, or any
// pixel arriving with a pixel still held after contour was turned off) blocks
// input while the second result is issued from a one-entry pending slot.
// After reset and after every config write the input stays closed while the
// threshold level is rebuilt by its two registered multiply steps.
// ----------------------------------------------------------------------------
module pixel_filter_pipeline
    import pfp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                      clk,
    input  logic                      rst_n,
    pfp_in_if.sink                    pix_in,
    pfp_out_if.source                 pix_out,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]     cfg_data
);

    typedef struct packed {
        logic [2:0][SAMPLE_BITS-1:0] px;
        logic                        last;
    } job_t;

    cfg_t                        cfg_reg;
    logic [SAMPLE_BITS:0]        level;
    logic                        busy;

    logic [2:0][SAMPLE_BITS-1:0] held_px_reg;
    logic                        held_valid_reg;
    logic [2:0][SAMPLE_BITS-1:0] held_px_next;
    logic                        held_valid_next;

    job_t                        pend_reg;
    logic                        pend_valid_reg;
    job_t                        pend_next;
    logic                        pend_valid_next;

    logic                        out_valid_reg;
    logic [2:0][SAMPLE_BITS-1:0] out_px_reg;
    logic                        out_last_reg;

    logic [2:0][SAMPLE_BITS-1:0] cur;
    logic [2:0][SAMPLE_BITS-1:0] diff;
    logic [2:0][SAMPLE_BITS-1:0] point_res;
    logic                        accept;
    logic                        advance;
    logic                        first_valid;
    logic                        second_valid;
    job_t                        first_job;
    job_t                        second_job;
    logic                        issue_valid;
    job_t                        issue_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_value           <= MAX_VALUE_RST;
            cfg_reg.color_mode          <= 1'b0;
            cfg_reg.contour_enable      <= 1'b0;
            cfg_reg.negate_enable       <= 1'b0;
            cfg_reg.threshold_enable    <= 1'b0;
            cfg_reg.threshold_percent   <= PCT_RST;
            cfg_reg.gray_convert_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_VALUE:     cfg_reg.max_value           <= cfg_data;
                REG_COLOR_MODE:    cfg_reg.color_mode          <= cfg_data[0];
                REG_CONTOUR_EN:    cfg_reg.contour_enable      <= cfg_data[0];
                REG_NEGATE_EN:     cfg_reg.negate_enable       <= cfg_data[0];
                REG_THRESHOLD_EN:  cfg_reg.threshold_enable    <= cfg_data[0];
                REG_THRESHOLD_PCT: cfg_reg.threshold_percent   <= cfg_data[PCT_BITS-1:0];
                REG_GRAY_CONVERT:  cfg_reg.gray_convert_enable <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    pfp_thresh #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_thresh (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .max_value         (cfg_reg.max_value),
        .threshold_percent (cfg_reg.threshold_percent),
        .level             (level),
        .busy              (busy)
    );

    assign advance      = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = advance && !pend_valid_reg && !busy;
    assign accept       = pix_in.valid && pix_in.ready;

    assign cur[0] = pix_in.red_or_gray[SAMPLE_BITS-1:0];
    assign cur[1] = pix_in.green[SAMPLE_BITS-1:0];
    assign cur[2] = pix_in.blue[SAMPLE_BITS-1:0];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            diff[c] = (cur[c] > held_px_reg[c]) ? (cur[c] - held_px_reg[c])
                                                : (held_px_reg[c] - cur[c]);
        end
    end

    // split one request into up to two jobs and update the held pixel
    always_comb
    begin
        first_valid     = 1'b0;
        second_valid    = 1'b0;
        first_job.px    = cur;
        first_job.last  = pix_in.last_of_image;
        second_job.px   = cur;
        second_job.last = pix_in.last_of_image;
        held_px_next    = held_px_reg;
        held_valid_next = held_valid_reg;

        if (!cfg_reg.contour_enable)
        begin
            first_valid = 1'b1;
            if (held_valid_reg)
            begin
                // flush the leftover pixel unchanged, then the current one
                first_job.px   = held_px_reg;
                first_job.last = 1'b0;
                second_valid   = 1'b1;
            end
            held_valid_next = 1'b0;
        end
        else
        begin
            if (held_valid_reg)
            begin
                first_valid    = 1'b1;
                first_job.px   = diff;
                first_job.last = 1'b0;
                second_valid   = pix_in.last_of_image;
                second_job.last = 1'b1;
            end
            else
            begin
                first_valid    = pix_in.last_of_image;
                first_job.last = 1'b1;
            end
            held_px_next    = cur;
            held_valid_next = !pix_in.last_of_image;
        end

        if (pend_valid_reg)
        begin
            issue_valid = 1'b1;
            issue_job   = pend_reg;
        end
        else
        begin
            issue_valid = accept && first_valid;
            issue_job   = first_job;
        end

        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (pend_valid_reg && advance)
        begin
            pend_valid_next = 1'b0;
        end
        else if (accept && second_valid)
        begin
            pend_valid_next = 1'b1;
            pend_next       = second_job;
        end
    end

    pfp_point #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_point (
        .cfg   (cfg_reg),
        .level (level),
        .px    (issue_job.px),
        .res   (point_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_valid_reg <= held_valid_next;
            end
            pend_valid_reg <= pend_valid_next;
            if (advance)
            begin
                out_valid_reg <= issue_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_px_reg <= held_px_next;
        end
        pend_reg <= pend_next;
        if (advance)
        begin
            out_px_reg   <= point_res;
            out_last_reg <= issue_job.last;
        end
    end

    assign pix_out.valid           = out_valid_reg;
    assign pix_out.out_red_or_gray = FIELD_BITS'(out_px_reg[0]);
    assign pix_out.out_green       = FIELD_BITS'(out_px_reg[1]);
    assign pix_out.out_blue        = FIELD_BITS'(out_px_reg[2]);
    assign pix_out.out_last        = out_last_reg;

endmodule

// ===== hdl/pfp_checker.sv =====
// ----------------------------------------------------------------------------
// pfp_checker
// port-level checks of the pixel filter pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "pixel_filter_pipeline_macros.svh"

module pfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_red_or_gray,
    input logic [15:0] out_green,
    input logic [15:0] out_blue,
    input logic        out_last,
    input logic        cfg_we
);

    // a stalled result keeps its valid and payload
    `PFP_ASSERT_NEXT(a_out_stall_hold, out_valid && !out_ready, out_valid && $stable(out_red_or_gray) && $stable(out_green) && $stable(out_blue) && $stable(out_last), "pfp: stalled result changed")

    // no new pixel while a result sits stalled in the output register
    `PFP_ASSERT_SAME(a_in_blocked_on_stall, out_valid && !out_ready, !in_ready, "pfp: input open while output stalled")

    // threshold level is rebuilt after a config write before pixels enter
    `PFP_ASSERT_NEXT(a_in_closed_after_cfg, cfg_we, !in_ready, "pfp: input open right after config write")

    // an offered pixel request stays up until it is taken
    `PFP_ASSERT_NEXT(a_in_request_held, in_valid && !in_ready, in_valid, "pfp: pixel request withdrawn before accept")

endmodule

bind pixel_filter_pipeline pfp_checker u_pfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (pix_in.valid),
    .in_ready        (pix_in.ready),
    .out_valid       (pix_out.valid),
    .out_ready       (pix_out.ready),
    .out_red_or_gray (pix_out.out_red_or_gray),
    .out_green       (pix_out.out_green),
    .out_blue        (pix_out.out_blue),
    .out_last        (pix_out.out_last),
    .cfg_we          (cfg_we)
);

// ===== dv/pixel_result_checker.sv =====
// ----------------------------------------------------------------------------
// pixel_result_checker
// Watches the pixel request and result channels and the config port of the
// pixel filter pipeline. It keeps its own copy of the settings and of the
// pixel held for the contour stage, works out the results that every accepted
// pixel request causes, and compares each accepted result with the oldest one
// still due.
// ----------------------------------------------------------------------------
module pixel_result_checker
    import pfp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    pfp_in_if                         pix_in,
    pfp_out_if                        pix_out,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]     cfg_data,
    output int unsigned               pending,
    output int unsigned               fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRAY_CHANNELS = 3;

    typedef struct packed {
        logic [FIELD_BITS-1:0] r;
        logic [FIELD_BITS-1:0] g;
        logic [FIELD_BITS-1:0] b;
        logic                  last;
    } px_result_t;

    cfg_t                        cfg;
    logic [2:0][FIELD_BITS-1:0]  held_px;
    logic                        held_ok;
    px_result_t                  due_results[$];

    function automatic logic [FIELD_BITS-1:0] abs_diff(input logic [FIELD_BITS-1:0] a,
                                                       input logic [FIELD_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // negate, threshold and gray averaging on one pixel
    function automatic px_result_t filter_pixel(input logic [2:0][FIELD_BITS-1:0] px,
                                                input logic lst);
        logic [2:0][FIELD_BITS-1:0] s;
        logic [31:0]                level;
        logic [17:0]                sum;
        px_result_t                 res;
        int                         n;
        int                         c;
        level = (32'(cfg.max_value) * 32'(cfg.threshold_percent)) / 32'd100;
        n = cfg.color_mode ? 3 : 1;
        s[0] = px[0];
        s[1] = cfg.color_mode ? px[1] : '0;
        s[2] = cfg.color_mode ? px[2] : '0;
        for (c = 0; c < n; c++)
        begin
            if (cfg.negate_enable)
                s[c] = (cfg.max_value > s[c]) ? cfg.max_value - s[c] : '0;
            if (cfg.threshold_enable)
                s[c] = (32'(s[c]) <= level) ? '0 : cfg.max_value;
        end
        if (cfg.color_mode && cfg.gray_convert_enable)
        begin
            sum  = 18'(s[0]) + 18'(s[1]) + 18'(s[2]);
            s[0] = FIELD_BITS'(sum / GRAY_CHANNELS);
            s[1] = '0;
            s[2] = '0;
        end
        res.r    = s[0];
        res.g    = s[1];
        res.b    = s[2];
        res.last = lst;
        return res;
    endfunction

    function automatic void predict_pixel(input logic [2:0][FIELD_BITS-1:0] cur,
                                          input logic lst);
        logic [2:0][FIELD_BITS-1:0] d;
        int                         c;
        if (!cfg.contour_enable)
        begin
            // contour turned off with a pixel still held: it goes out first
            if (held_ok)
                due_results.push_back(filter_pixel(held_px, 1'b0));
            held_ok = 1'b0;
            held_px = '0;
            due_results.push_back(filter_pixel(cur, lst));
        end
        else
        begin
            if (held_ok)
            begin
                for (c = 0; c < 3; c++)
                    d[c] = abs_diff(cur[c], held_px[c]);
                due_results.push_back(filter_pixel(d, 1'b0));
            end
            if (lst)
            begin
                due_results.push_back(filter_pixel(cur, 1'b1));
                held_ok = 1'b0;
                held_px = '0;
            end
            else
            begin
                held_px = cur;
                held_ok = 1'b1;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        px_result_t got;
        px_result_t want;
        if (!rst_n)
        begin
            cfg.max_value           = MAX_VALUE_RST;
            cfg.color_mode          = 1'b0;
            cfg.contour_enable      = 1'b0;
            cfg.negate_enable       = 1'b0;
            cfg.threshold_enable    = 1'b0;
            cfg.threshold_percent   = PCT_RST;
            cfg.gray_convert_enable = 1'b0;
            held_px    = '0;
            held_ok    = 1'b0;
            fail_count = 0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            // a result never leaves in the same cycle as its request, so check first
            if (pix_out.valid && pix_out.ready)
            begin
                got = '{pix_out.out_red_or_gray, pix_out.out_green, pix_out.out_blue,
                        pix_out.out_last};
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result r=%h g=%h b=%h last=%b",
                             $time, got.r, got.g, got.b, got.last);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.r !== want.r || got.g !== want.g || got.b !== want.b
                        || got.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected r=%h g=%h b=%h last=%b",
                                 $time, want.r, want.g, want.b, want.last);
                        $display("%0t:          actual   r=%h g=%h b=%h last=%b",
                                 $time, got.r, got.g, got.b, got.last);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_VALUE:     cfg.max_value           = cfg_data;
                    REG_COLOR_MODE:    cfg.color_mode          = cfg_data[0];
                    REG_CONTOUR_EN:    cfg.contour_enable      = cfg_data[0];
                    REG_NEGATE_EN:     cfg.negate_enable       = cfg_data[0];
                    REG_THRESHOLD_EN:  cfg.threshold_enable    = cfg_data[0];
                    REG_THRESHOLD_PCT: cfg.threshold_percent   = cfg_data[PCT_BITS-1:0];
                    REG_GRAY_CONVERT:  cfg.gray_convert_enable = cfg_data[0];
                    default: ;
                endcase
            end
            if (pix_in.valid && pix_in.ready)
                predict_pixel({pix_in.blue, pix_in.green, pix_in.red_or_gray},
                              pix_in.last_of_image);
            pending <= due_results.size();
        end
    end

endmodule

// ===== dv/tb_pixel_filter_pipeline.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_filter_pipeline
// Drives the pixel filter pipeline with a short directed set covering every
// stage and its corner cases, then with random images under random settings.
// Both channel sides idle at random, the result side holds off once for a
// long stretch; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_pixel_filter_pipeline;
    timeunit 1ns;
    timeprecision 1ps;

    import pfp_pkg::*;

    localparam int RESET_CYCLES      = 8;
    localparam int DRAIN_CYCLES      = 8;
    localparam int RANDOM_PHASES     = 14;
    localparam int PHASE_ITEMS       = 93;
    localparam int STALL_PHASE       = 3;
    localparam int STEADY_PHASE      = 6;
    localparam int LONG_STALL_CYCLES = 150;
    localparam int GAP_PERCENT       = 27;
    localparam int TIMEOUT_NS        = 800000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [FIELD_BITS-1:0]     cfg_data;
    int unsigned               pending;
    int unsigned               fail_count;
    bit                        quiet = 1'b0;
    bit                        long_stall_req = 1'b0;

    pfp_in_if  pix_in();
    pfp_out_if pix_out();

    pixel_filter_pipeline dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .pix_out    (pix_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always #2 clk = ~clk;

    function automatic bit take_gap();
        return !quiet && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    function automatic cfg_t make_settings(input logic [15:0] mx, input logic rgb,
                                           input logic contour, input logic neg,
                                           input logic thr, input logic [6:0] pct,
                                           input logic gray);
        cfg_t c;
        c.max_value           = mx;
        c.color_mode          = rgb;
        c.contour_enable      = contour;
        c.negate_enable       = neg;
        c.threshold_enable    = thr;
        c.threshold_percent   = pct;
        c.gray_convert_enable = gray;
        return c;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        case ($urandom_range(5))
            0: c.max_value = 16'd0;
            1: c.max_value = 16'd1;
            2: c.max_value = 16'd255;
            3: c.max_value = 16'hFFFF;
            default: c.max_value = 16'($urandom);
        endcase
        case ($urandom_range(4))
            0: c.threshold_percent = 7'd0;
            1: c.threshold_percent = 7'd100;
            2: c.threshold_percent = 7'd127;
            default: c.threshold_percent = 7'($urandom_range(100));
        endcase
        c.color_mode          = 1'($urandom_range(1));
        c.contour_enable      = 1'($urandom_range(1));
        c.negate_enable       = 1'($urandom_range(1));
        c.threshold_enable    = 1'($urandom_range(1));
        c.gray_convert_enable = 1'($urandom_range(1));
        return c;
    endfunction

    // samples bunch around zero, max and the threshold level
    function automatic logic [15:0] pick_sample(input cfg_t c);
        logic [31:0] level;
        level = (32'(c.max_value) * 32'(c.threshold_percent)) / 32'd100;
        case ($urandom_range(6))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return c.max_value + 16'($urandom_range(2)) - 16'd1;
            3: return 16'(level) + 16'($urandom_range(1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic lst);
        while (take_gap())
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid         <= 1'b1;
        pix_in.red_or_gray   <= r;
        pix_in.green         <= g;
        pix_in.blue          <= b;
        pix_in.last_of_image <= lst;
        do @(posedge clk); while (!pix_in.ready);
    endtask

    // no request open and no result due, then a further wait for a held pixel
    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // upper bits of narrow registers carry noise, the block must mask them
    task automatic program_regs(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_VALUE;
        cfg_data  <= c.max_value;
        @(posedge clk);
        cfg_index <= REG_COLOR_MODE;
        cfg_data  <= {15'($urandom), c.color_mode};
        @(posedge clk);
        cfg_index <= REG_CONTOUR_EN;
        cfg_data  <= {15'($urandom), c.contour_enable};
        @(posedge clk);
        cfg_index <= REG_NEGATE_EN;
        cfg_data  <= {15'($urandom), c.negate_enable};
        @(posedge clk);
        cfg_index <= REG_THRESHOLD_EN;
        cfg_data  <= {15'($urandom), c.threshold_enable};
        @(posedge clk);
        cfg_index <= REG_THRESHOLD_PCT;
        cfg_data  <= {9'($urandom), c.threshold_percent};
        @(posedge clk);
        cfg_index <= REG_GRAY_CONVERT;
        cfg_data  <= {15'($urandom), c.gray_convert_enable};
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result side: random holds, plus one long hold-off to back up the block
    initial
    begin
        int unsigned stall_left;
        bit          stall_taken;
        stall_left  = 0;
        stall_taken = 1'b0;
        pix_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_stall_req && !stall_taken)
            begin
                stall_taken = 1'b1;
                stall_left  = LONG_STALL_CYCLES;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                pix_out.ready <= 1'b0;
            end
            else
                pix_out.ready <= !take_gap();
        end
    end

    initial
    begin
        cfg_t        s;
        int unsigned img_left;
        logic        lst;
        rst_n                <= 1'b0;
        pix_in.valid         <= 1'b0;
        pix_in.red_or_gray   <= '0;
        pix_in.green         <= '0;
        pix_in.blue          <= '0;
        pix_in.last_of_image <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_MAX_VALUE;
        cfg_data             <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // settings after reset: plain pass-through of gray samples
        send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_pixel(16'd255, 16'h1234, 16'h5678, 1'b1);

        wait_drained();
        program_regs(make_settings(16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b0, 7'd50, 1'b0));
        send_pixel(16'd0, 16'hFFFF, 16'h8000, 1'b0);
        send_pixel(16'hFFFF, 16'd0, 16'd1, 1'b1);

        // samples above max, percent above 100, gray conversion enabled in gray mode
        wait_drained();
        program_regs(make_settings(16'd200, 1'b0, 1'b0, 1'b1, 1'b1, 7'd127, 1'b1));
        send_pixel(16'd300, 16'hAAAA, 16'h5555, 1'b0);
        send_pixel(16'd0, 16'h5555, 16'hAAAA, 1'b1);

        // zero max
        wait_drained();
        program_regs(make_settings(16'd0, 1'b1, 1'b0, 1'b1, 1'b1, 7'd0, 1'b1));
        send_pixel(16'd5, 16'd6, 16'd7, 1'b1);

        wait_drained();
        program_regs(make_settings(16'd1, 1'b1, 1'b0, 1'b0, 1'b1, 7'd0, 1'b1));
        send_pixel(16'd0, 16'd1, 16'd1, 1'b0);
        send_pixel(16'd1, 16'd1, 16'd1, 1'b1);

        // contour: held pixels, a last pixel releasing one, a lone last pixel
        wait_drained();
        program_regs(make_settings(16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 7'd100, 1'b0));
        send_pixel(16'd100, 16'd200, 16'd300, 1'b0);
        send_pixel(16'd50, 16'hFFFF, 16'd300, 1'b0);
        send_pixel(16'd0, 16'd0, 16'd0, 1'b1);
        send_pixel(16'd7, 16'd8, 16'd9, 1'b1);
        send_pixel(16'd1, 16'd2, 16'd3, 1'b0);

        // contour switched off with a pixel still held
        wait_drained();
        program_regs(make_settings(16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b0, 7'd100, 1'b0));
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

        wait_drained();
        program_regs(make_settings(16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b1, 7'd50, 1'b1));
        send_pixel(16'hFFFF, 16'd0, 16'h8000, 1'b0);
        send_pixel(16'd0, 16'hFFFF, 16'h7FFF, 1'b1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            s = random_settings();
            wait_drained();
            program_regs(s);
            quiet = (phase == STEADY_PHASE);
            if (phase == STALL_PHASE)
                long_stall_req = 1'b1;
            img_left = 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (img_left == 0)
                    img_left = ($urandom_range(7) == 0) ? 1 : $urandom_range(12, 2);
                img_left--;
                lst = (img_left == 0);
                // broken images now and then
                if ($urandom_range(9) == 0)
                    lst = 1'($urandom_range(1));
                send_pixel(pick_sample(s), pick_sample(s), pick_sample(s), lst);
            end
        end
        quiet = 1'b0;

        wait_drained();
        @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pfp_pkg.sv
hdl/pfp_if.sv
hdl/pfp_thresh.sv
hdl/pfp_point.sv
hdl/pixel_filter_pipeline.sv
hdl/pfp_checker.sv
dv/pixel_result_checker.sv
dv/tb_pixel_filter_pipeline.sv
